@@ src/rtsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Rolling token session guard package
// Shared types and codes for the top, front and back of the session guard.
// ----------------------------------------------------------------------------
`default_nettype none

package rtsg_pkg;

   // Request mode codes as they arrive on the request channel.
   localparam logic [2:0] MODE_PAIR      = 3'd0;
   localparam logic [2:0] MODE_CLAIM     = 3'd1;
   localparam logic [2:0] MODE_VALIDATE  = 3'd2;
   localparam logic [2:0] MODE_HEARTBEAT = 3'd3;
   localparam logic [2:0] MODE_CLOSE     = 3'd4;
   localparam logic [2:0] MODE_TICK      = 3'd5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PAIRING_TTL = 2'd0;
   localparam logic [1:0] CSR_SESSION_TTL = 2'd1;
   localparam logic [1:0] CSR_PREV_GRACE  = 2'd2;

   localparam logic [31:0] PAIRING_TTL_RESET = 32'd300000;
   localparam logic [31:0] SESSION_TTL_RESET = 32'd600000;
   localparam logic [31:0] PREV_GRACE_RESET  = 32'd30000;

   typedef enum logic [2:0] {
      OP_PAIR,
      OP_CLAIM,
      OP_VALIDATE,
      OP_HEARTBEAT,
      OP_CLOSE,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_WAIT    = 2'd1,
      PH_ACTIVE  = 2'd2,
      PH_EXPIRED = 2'd3
   } phase_type;

   // Classified request, as it travels from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic        present;
      logic [31:0] pair_dl;
      logic [31:0] sess_dl;
      logic [31:0] prev_dl;
   } cmd_type;

endpackage

`default_nettype wire

@@ src/rolling_token_session_guard_top.sv @@
// ----------------------------------------------------------------------------
// Rolling token session guard
// Pairing, claim and rolling bearer token checks for one session.
// ----------------------------------------------------------------------------
// Usage:
// A request word enters on req_* when req_valid is high and req_stall is low.
// Each request word yields exactly one response word on rsp_*, taken when
// rsp_valid is high and rsp_stall is low; responses keep request order.
// The front end decodes the mode and adds the TTL registers to req_now_ms,
// a two-entry queue follows, and the back end updates the session state
// and loads the response register in the same cycle.
// Between request accept and response accept lie a queue slot and the response register.
// Throughput is one word per cycle while rsp_stall stays low and words arrive;
// the queue and response register let both sides stall freely.
// When rsp_stall holds, the response register holds its word, the queue fills
// and req_stall rises once both queue entries are occupied.
// Reset clears the phase to idle, drops all tokens and deadlines, empties the
// queue and loads the TTL registers with 300000, 600000 and 30000 ms.
// The csr_* port writes a TTL register; write only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_token_session_guard_top
   import rtsg_pkg::*;
#(
   parameter int TOKEN_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [31:0]           csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_mode,
   input  wire logic [31:0]           req_now_ms,
   input  wire logic [TOKEN_BITS-1:0] req_bearer_token,
   input  wire logic                  req_bearer_present,
   input  wire logic [TOKEN_BITS-1:0] req_fresh_token_a,
   input  wire logic [TOKEN_BITS-1:0] req_fresh_token_b,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic [TOKEN_BITS-1:0]      rsp_token_out,
   output logic                       rsp_token_out_present,
   output logic [1:0]                 rsp_phase,
   output logic                       rsp_pairing_open
);

   // Queue entry: the classified command followed by the three tokens.
   localparam int CMD_BITS   = $bits(cmd_type);
   localparam int ENTRY_BITS = CMD_BITS + 3 * TOKEN_BITS;

   cmd_type               front_cmd;
   cmd_type               back_cmd;
   logic [ENTRY_BITS-1:0] q_wdata;
   logic [ENTRY_BITS-1:0] q_rdata;
   logic                  q_full;
   logic                  q_valid;
   logic                  q_pop;
   logic                  q_push;
   logic [TOKEN_BITS-1:0] q_bearer;
   logic [TOKEN_BITS-1:0] q_fresh_a;
   logic [TOKEN_BITS-1:0] q_fresh_b;

   rtsg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_mode           (req_mode),
      .req_now_ms         (req_now_ms),
      .req_bearer_present (req_bearer_present),
      .cmd                (front_cmd)
   );

   // The queue takes a word whenever it has room, independent of the back end.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_wdata   = {front_cmd, req_bearer_token, req_fresh_token_a, req_fresh_token_b};

   rtsg_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   assign back_cmd  = cmd_type'(q_rdata[ENTRY_BITS-1 -: CMD_BITS]);
   assign q_bearer  = q_rdata[3*TOKEN_BITS-1 -: TOKEN_BITS];
   assign q_fresh_a = q_rdata[2*TOKEN_BITS-1 -: TOKEN_BITS];
   assign q_fresh_b = q_rdata[TOKEN_BITS-1:0];

   rtsg_back #(
      .TOKEN_BITS (TOKEN_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .cmd                   (back_cmd),
      .bearer                (q_bearer),
      .fresh_a               (q_fresh_a),
      .fresh_b               (q_fresh_b),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_accepted          (rsp_accepted),
      .rsp_token_out         (rsp_token_out),
      .rsp_token_out_present (rsp_token_out_present),
      .rsp_phase             (rsp_phase),
      .rsp_pairing_open      (rsp_pairing_open)
   );

endmodule

`default_nettype wire

@@ src/rtsg_front.sv @@
// ----------------------------------------------------------------------------
// Session guard front end
// Holds the TTL registers, decodes the request mode and precomputes deadlines.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsg_front
   import rtsg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic [2:0]  req_mode,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_bearer_present,
   output cmd_type          cmd
);

   logic [31:0] pairing_ttl_ff;
   logic [31:0] session_ttl_ff;
   logic [31:0] prev_grace_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pairing_ttl_ff <= PAIRING_TTL_RESET;
         session_ttl_ff <= SESSION_TTL_RESET;
         prev_grace_ff  <= PREV_GRACE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PAIRING_TTL: pairing_ttl_ff <= csr_wdata;
            CSR_SESSION_TTL: session_ttl_ff <= csr_wdata;
            CSR_PREV_GRACE:  prev_grace_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (req_mode)
         MODE_PAIR:      cmd.op = OP_PAIR;
         MODE_CLAIM:     cmd.op = OP_CLAIM;
         MODE_VALIDATE:  cmd.op = OP_VALIDATE;
         MODE_HEARTBEAT: cmd.op = OP_HEARTBEAT;
         MODE_CLOSE:     cmd.op = OP_CLOSE;
         MODE_TICK:      cmd.op = OP_TICK;
         default:        cmd.op = OP_NONE;
      endcase
      cmd.now_ms  = req_now_ms;
      cmd.present = req_bearer_present;
      // Deadlines wrap modulo 2^32.
      cmd.pair_dl = req_now_ms + pairing_ttl_ff;
      cmd.sess_dl = req_now_ms + session_ttl_ff;
      cmd.prev_dl = req_now_ms + prev_grace_ff;
   end

endmodule

`default_nettype wire

@@ src/rtsg_queue.sv @@
// ----------------------------------------------------------------------------
// Session guard command queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsg_queue #(
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] wdata,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      valid,
   output logic [DATA_BITS-1:0]      rdata
);

   logic [DATA_BITS-1:0] slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign rdata = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ src/rtsg_back.sv @@
// ----------------------------------------------------------------------------
// Session guard back end
// Holds the session state, executes one command per cycle unless the response stalls, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsg_back
   import rtsg_pkg::*;
#(
   parameter int TOKEN_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire cmd_type               cmd,
   input  wire logic [TOKEN_BITS-1:0] bearer,
   input  wire logic [TOKEN_BITS-1:0] fresh_a,
   input  wire logic [TOKEN_BITS-1:0] fresh_b,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic [TOKEN_BITS-1:0]      rsp_token_out,
   output logic                       rsp_token_out_present,
   output logic [1:0]                 rsp_phase,
   output logic                       rsp_pairing_open
);

   phase_type             phase_ff, phase_in;
   logic [TOKEN_BITS-1:0] pair_tok_ff, pair_tok_in;
   logic [TOKEN_BITS-1:0] sess_tok_ff, sess_tok_in;
   logic [TOKEN_BITS-1:0] next_tok_ff, next_tok_in;
   logic [TOKEN_BITS-1:0] prev_tok_ff, prev_tok_in;
   logic                  pair_vld_ff, pair_vld_in;
   logic                  sess_vld_ff, sess_vld_in;
   logic                  next_vld_ff, next_vld_in;
   logic                  prev_vld_ff, prev_vld_in;
   logic [31:0]           pair_dl_ff, pair_dl_in;
   logic [31:0]           sess_dl_ff, sess_dl_in;
   logic [31:0]           prev_dl_ff, prev_dl_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  acc_ff, acc_in;
   logic [TOKEN_BITS-1:0] tok_ff, tok_in;
   logic                  tp_ff, tp_in;
   logic                  open_ff, open_in;

   logic bearer_ok;
   logic sess_hit;
   logic next_hit;
   logic prev_hit;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sess_hit  = sess_vld_ff && (bearer == sess_tok_ff);
      next_hit  = next_vld_ff && (bearer == next_tok_ff);
      prev_hit  = prev_vld_ff && (bearer == prev_tok_ff) && (cmd.now_ms <= prev_dl_ff);
      bearer_ok = (phase_ff == PH_ACTIVE) && (cmd.now_ms <= sess_dl_ff) && cmd.present
                  && (sess_hit || next_hit || prev_hit);
   end

   always_comb begin
      phase_in    = phase_ff;
      pair_tok_in = pair_tok_ff;
      sess_tok_in = sess_tok_ff;
      next_tok_in = next_tok_ff;
      prev_tok_in = prev_tok_ff;
      pair_vld_in = pair_vld_ff;
      sess_vld_in = sess_vld_ff;
      next_vld_in = next_vld_ff;
      prev_vld_in = prev_vld_ff;
      pair_dl_in  = pair_dl_ff;
      sess_dl_in  = sess_dl_ff;
      prev_dl_in  = prev_dl_ff;
      acc_in      = 1'b0;
      tp_in       = 1'b0;
      tok_in      = '0;

      case (cmd.op)
         OP_PAIR: begin
            pair_tok_in = fresh_a;
            pair_vld_in = 1'b1;
            pair_dl_in  = cmd.pair_dl;
            sess_vld_in = 1'b0;
            next_vld_in = 1'b0;
            prev_vld_in = 1'b0;
            sess_dl_in  = '0;
            prev_dl_in  = '0;
            phase_in    = PH_WAIT;
            acc_in      = 1'b1;
            tp_in       = 1'b1;
            tok_in      = fresh_a;
         end
         OP_CLAIM: begin
            if (pair_vld_ff && cmd.present && (bearer == pair_tok_ff)) begin
               // A matching pairing token is consumed whether or not it expired.
               pair_vld_in = 1'b0;
               if (cmd.now_ms <= pair_dl_ff) begin
                  sess_tok_in = fresh_a;
                  sess_vld_in = 1'b1;
                  next_tok_in = fresh_b;
                  next_vld_in = 1'b1;
                  prev_vld_in = 1'b0;
                  prev_dl_in  = '0;
                  sess_dl_in  = cmd.sess_dl;
                  phase_in    = PH_ACTIVE;
                  acc_in      = 1'b1;
                  tp_in       = 1'b1;
                  tok_in      = fresh_a;
               end
            end
         end
         OP_VALIDATE: begin
            acc_in = bearer_ok;
         end
         OP_HEARTBEAT: begin
            if (bearer_ok) begin
               prev_tok_in = next_tok_ff;
               prev_vld_in = next_vld_ff;
               prev_dl_in  = cmd.prev_dl;
               if (sess_hit) begin
                  sess_tok_in = next_tok_ff;
                  sess_vld_in = next_vld_ff;
               end
               next_tok_in = fresh_a;
               next_vld_in = 1'b1;
               sess_dl_in  = cmd.sess_dl;
               acc_in      = 1'b1;
               tp_in       = 1'b1;
               tok_in      = fresh_a;
            end
         end
         OP_CLOSE: begin
            if (bearer_ok) begin
               phase_in    = PH_EXPIRED;
               sess_vld_in = 1'b0;
               next_vld_in = 1'b0;
               prev_vld_in = 1'b0;
               sess_dl_in  = '0;
               prev_dl_in  = '0;
               acc_in      = 1'b1;
            end
         end
         OP_TICK: begin
            if ((phase_ff == PH_ACTIVE) && (cmd.now_ms > sess_dl_ff)) begin
               phase_in    = PH_EXPIRED;
               sess_vld_in = 1'b0;
               next_vld_in = 1'b0;
            end
            if (prev_vld_ff && (cmd.now_ms > prev_dl_ff)) begin
               prev_vld_in = 1'b0;
            end
            acc_in = 1'b1;
         end
         default: ;
      endcase

      open_in = (phase_in == PH_WAIT) && pair_vld_in && (cmd.now_ms <= pair_dl_in);
      rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pair_vld_ff  <= 1'b0;
         sess_vld_ff  <= 1'b0;
         next_vld_ff  <= 1'b0;
         prev_vld_ff  <= 1'b0;
         pair_dl_ff   <= '0;
         sess_dl_ff   <= '0;
         prev_dl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff    <= phase_in;
            pair_vld_ff <= pair_vld_in;
            sess_vld_ff <= sess_vld_in;
            next_vld_ff <= next_vld_in;
            prev_vld_ff <= prev_vld_in;
            pair_dl_ff  <= pair_dl_in;
            sess_dl_ff  <= sess_dl_in;
            prev_dl_ff  <= prev_dl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pair_tok_ff <= pair_tok_in;
         sess_tok_ff <= sess_tok_in;
         next_tok_ff <= next_tok_in;
         prev_tok_ff <= prev_tok_in;
         acc_ff      <= acc_in;
         tok_ff      <= tok_in;
         tp_ff       <= tp_in;
         open_ff     <= open_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = acc_ff;
   assign rsp_token_out         = tok_ff;
   assign rsp_token_out_present = tp_ff;
   assign rsp_phase             = phase_ff;
   assign rsp_pairing_open      = open_ff;

   // An open pairing window is only ever reported in the waiting phase.
   a_open_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && open_ff |-> phase_ff == PH_WAIT)
      else $error("pairing_open reported outside the waiting phase");

   // A word without a token carries a zero token field.
   a_no_token_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !tp_ff |-> tok_ff == '0)
      else $error("token_out nonzero while token_out_present is low");

   // An active session always holds a next token.
   a_active_has_next: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ACTIVE |-> next_vld_ff)
      else $error("active phase without a valid next token");

   // An unknown mode is never accepted.
   a_none_rejected: assert property (@(posedge clock) disable iff (reset)
      q_pop && cmd.op == OP_NONE |=> !acc_ff)
      else $error("unknown mode reported as accepted");

endmodule

`default_nettype wire
